>>> design/srtf_pkg.sv
// Shared types and constants for the SRTF scheduler.
package srtf_pkg;
   localparam int READY_SLOTS = 16;
   localparam int SLOT_W = $clog2(READY_SLOTS);

   localparam logic [1:0] STATUS_OK = 2'd0;
   localparam logic [1:0] STATUS_FULL = 2'd1;
   localparam logic [1:0] STATUS_ZERO = 2'd2;

   localparam logic KIND_ARRIVAL = 1'b0;
   localparam logic KIND_TICK = 1'b1;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic load;        // capture the input word
      logic scan_clear;  // start a new search over the slots
      logic scan_step;   // compare one slot
      logic finish;      // apply the arrival or the tick
   } srtf_cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic scan_last;   // the slot compared in this step is the last one
   } srtf_sts_type;
endpackage

>>> design/srtf_datapath.sv
// Datapath of the SRTF scheduler: slot table, running job, search and totals.
module srtf_datapath (
   input  logic                    clock,
   input  logic                    reset,
   input  srtf_pkg::srtf_cmd_type  cmd,
   output srtf_pkg::srtf_sts_type  sts,
   input  logic                    req_kind,
   input  logic [7:0]              req_job_id,
   input  logic [11:0]             req_burst_len,
   output logic [1:0]              rsp_status,
   output logic                    rsp_run_valid,
   output logic [7:0]              rsp_run_id,
   output logic                    rsp_done_valid,
   output logic [7:0]              rsp_done_id,
   output logic [15:0]             rsp_done_time,
   output logic [15:0]             rsp_turnaround,
   output logic [15:0]             rsp_wait_len,
   output logic [31:0]             rsp_wait_total,
   output logic [31:0]             rsp_turnaround_total
);
   import srtf_pkg::*;

   logic [READY_SLOTS-1:0] used_ff, used_in;
   logic [7:0]  job_ff [READY_SLOTS];
   logic [15:0] arr_ff [READY_SLOTS];
   logic [11:0] bur_ff [READY_SLOTS];
   logic [11:0] rem_ff [READY_SLOTS];

   logic        kind_ff;
   logic [7:0]  id_ff;
   logic [11:0] burst_ff;

   logic        busy_ff, busy_in;
   logic [7:0]  cjob_ff, cjob_in;
   logic [15:0] carr_ff, carr_in;
   logic [11:0] cbur_ff, cbur_in;
   logic [11:0] crem_ff, crem_in;
   logic [15:0] now_ff;
   logic [31:0] swait_ff, swait_in, sturn_ff, sturn_in;

   // Search state: index walks all slots; best holds the winner so far.
   logic [SLOT_W-1:0] idx_ff;
   logic              found_ff, free_found_ff;
   logic [SLOT_W-1:0] best_ff, free_ff;

   logic better;
   logic done;
   logic [15:0] turn;
   logic [11:0] crem_after;

   assign sts.scan_last = (idx_ff == SLOT_W'(READY_SLOTS - 1));

   // The slot under the index beats the best so far.
   always_comb begin
      better = 1'b0;
      if (used_ff[idx_ff]) begin
         if (!found_ff) begin
            better = 1'b1;
         end else if (rem_ff[idx_ff] != rem_ff[best_ff]) begin
            better = rem_ff[idx_ff] < rem_ff[best_ff];
         end else if (arr_ff[idx_ff] != arr_ff[best_ff]) begin
            better = arr_ff[idx_ff] < arr_ff[best_ff];
         end else begin
            better = job_ff[idx_ff] < job_ff[best_ff];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         idx_ff <= '0;
         found_ff <= 1'b0;
         free_found_ff <= 1'b0;
      end else if (cmd.scan_clear) begin
         idx_ff <= '0;
         found_ff <= 1'b0;
         free_found_ff <= 1'b0;
      end else if (cmd.scan_step) begin
         if (!sts.scan_last) begin
            idx_ff <= idx_ff + SLOT_W'(1);
         end
         if (better) begin
            found_ff <= 1'b1;
            best_ff <= idx_ff;
         end
         if (!used_ff[idx_ff] && !free_found_ff) begin
            free_found_ff <= 1'b1;
            free_ff <= idx_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         kind_ff <= req_kind;
         id_ff <= req_job_id;
         burst_ff <= req_burst_len;
      end
   end

   assign done = busy_ff && (crem_ff == 12'd0);
   assign turn = now_ff - carr_ff;

   always_comb begin
      logic busy_mid;
      logic [31:0] s;
      logic [15:0] w;
      busy_mid = busy_ff && !done;
      s = '0;
      w = (turn >= {4'd0, cbur_ff}) ? (turn - {4'd0, cbur_ff}) : 16'd0;
      used_in = used_ff;
      busy_in = busy_mid;
      cjob_in = cjob_ff;
      carr_in = carr_ff;
      cbur_in = cbur_ff;
      crem_in = crem_ff;
      swait_in = swait_ff;
      sturn_in = sturn_ff;
      if (done) begin
         s = swait_ff + {16'd0, w};
         swait_in = (s < swait_ff) ? 32'hFFFF_FFFF : s;
         s = sturn_ff + {16'd0, turn};
         sturn_in = (s < sturn_ff) ? 32'hFFFF_FFFF : s;
      end
      if (found_ff) begin
         if (busy_mid) begin
            if (rem_ff[best_ff] < crem_ff) begin
               cjob_in = job_ff[best_ff];
               carr_in = arr_ff[best_ff];
               cbur_in = bur_ff[best_ff];
               crem_in = rem_ff[best_ff];
            end
         end else begin
            cjob_in = job_ff[best_ff];
            carr_in = arr_ff[best_ff];
            cbur_in = bur_ff[best_ff];
            crem_in = rem_ff[best_ff];
            used_in[best_ff] = 1'b0;
            busy_in = 1'b1;
         end
      end
      crem_after = (busy_in && crem_in != 12'd0) ? crem_in - 12'd1 : crem_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         used_ff <= '0;
         busy_ff <= 1'b0;
         cjob_ff <= '0;
         carr_ff <= '0;
         cbur_ff <= '0;
         crem_ff <= '0;
         now_ff <= '0;
         swait_ff <= '0;
         sturn_ff <= '0;
         rsp_run_valid <= 1'b0;
         rsp_run_id <= '0;
         rsp_wait_total <= '0;
         rsp_turnaround_total <= '0;
      end else if (cmd.finish) begin
         rsp_done_valid <= 1'b0;
         rsp_done_id <= '0;
         rsp_done_time <= '0;
         rsp_turnaround <= '0;
         rsp_wait_len <= '0;
         rsp_status <= STATUS_OK;
         if (kind_ff == KIND_ARRIVAL) begin
            if (burst_ff == 12'd0) begin
               rsp_status <= STATUS_ZERO;
            end else if (!free_found_ff) begin
               rsp_status <= STATUS_FULL;
            end else begin
               used_ff[free_ff] <= 1'b1;
               job_ff[free_ff] <= id_ff;
               arr_ff[free_ff] <= now_ff;
               bur_ff[free_ff] <= burst_ff;
               rem_ff[free_ff] <= burst_ff;
            end
            rsp_run_valid <= busy_ff;
            rsp_run_id <= busy_ff ? cjob_ff : 8'd0;
            rsp_wait_total <= swait_ff;
            rsp_turnaround_total <= sturn_ff;
         end else begin
            used_ff <= used_in;
            // A preempted job swaps into the winner's slot.
            if (found_ff && busy_ff && !done && rem_ff[best_ff] < crem_ff) begin
               job_ff[best_ff] <= cjob_ff;
               arr_ff[best_ff] <= carr_ff;
               bur_ff[best_ff] <= cbur_ff;
               rem_ff[best_ff] <= crem_ff;
            end
            busy_ff <= busy_in;
            cjob_ff <= cjob_in;
            carr_ff <= carr_in;
            cbur_ff <= cbur_in;
            crem_ff <= crem_after;
            now_ff <= now_ff + 16'd1;
            swait_ff <= swait_in;
            sturn_ff <= sturn_in;
            rsp_run_valid <= busy_in;
            rsp_run_id <= busy_in ? cjob_in : 8'd0;
            rsp_wait_total <= swait_in;
            rsp_turnaround_total <= sturn_in;
            if (done) begin
               rsp_done_valid <= 1'b1;
               rsp_done_id <= cjob_ff;
               rsp_done_time <= now_ff;
               rsp_turnaround <= turn;
               rsp_wait_len <= (turn >= {4'd0, cbur_ff}) ? (turn - {4'd0, cbur_ff}) : 16'd0;
            end
         end
      end
   end
endmodule

>>> design/srtf_control.sv
// Controller of the SRTF scheduler: handshakes and slot scan sequencing.
module srtf_control (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_ready,
   output logic                    rsp_valid,
   input  logic                    rsp_ready,
   output srtf_pkg::srtf_cmd_type  cmd,
   input  srtf_pkg::srtf_sts_type  sts
);
   import srtf_pkg::*;

   typedef enum logic [3:0] {
      ST_IDLE = 4'b0001,
      ST_SCAN = 4'b0010,
      ST_DONE = 4'b0100,
      ST_OUT  = 4'b1000
   } state_type;

   state_type state_ff, state_in;

   assign req_ready = (state_ff == ST_IDLE);
   assign rsp_valid = (state_ff == ST_OUT);

   always_comb begin
      cmd = '0;
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd.load = 1'b1;
               cmd.scan_clear = 1'b1;
               state_in = ST_SCAN;
            end
         end
         ST_SCAN: begin
            cmd.scan_step = 1'b1;
            if (sts.scan_last) begin
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            cmd.finish = 1'b1;
            state_in = ST_OUT;
         end
         ST_OUT: begin
            if (rsp_ready) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end
endmodule

>>> design/srtf_preemptive_scheduler.sv
// Top level of the preemptive shortest-remaining-time-first scheduler.
// Each input word (an arrival or a tick) is handled in steps: the accepting
// edge captures the word, a sequential search over all slots finds the best
// ready job and the lowest free slot, and a final step updates state and
// registers the result. The result then waits in its register until taken.
// One word is handled at a time; a new word can be accepted in the cycle
// after the previous result has been taken.
module srtf_preemptive_scheduler (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic        req_kind,
   input  logic [7:0]  req_job_id,
   input  logic [11:0] req_burst_len,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [1:0]  rsp_status,
   output logic        rsp_run_valid,
   output logic [7:0]  rsp_run_id,
   output logic        rsp_done_valid,
   output logic [7:0]  rsp_done_id,
   output logic [15:0] rsp_done_time,
   output logic [15:0] rsp_turnaround,
   output logic [15:0] rsp_wait_len,
   output logic [31:0] rsp_wait_total,
   output logic [31:0] rsp_turnaround_total
);
   import srtf_pkg::*;

   srtf_cmd_type cmd;
   srtf_sts_type sts;

   srtf_control u_control (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready),
      .cmd(cmd), .sts(sts)
   );

   srtf_datapath u_datapath (
      .clock(clock), .reset(reset), .cmd(cmd), .sts(sts),
      .req_kind(req_kind), .req_job_id(req_job_id), .req_burst_len(req_burst_len),
      .rsp_status(rsp_status), .rsp_run_valid(rsp_run_valid),
      .rsp_run_id(rsp_run_id), .rsp_done_valid(rsp_done_valid),
      .rsp_done_id(rsp_done_id), .rsp_done_time(rsp_done_time),
      .rsp_turnaround(rsp_turnaround), .rsp_wait_len(rsp_wait_len),
      .rsp_wait_total(rsp_wait_total), .rsp_turnaround_total(rsp_turnaround_total)
   );

   a_no_overlap: assert property (@(posedge clock) disable iff (reset)
      !(req_ready && rsp_valid)) else $error("input taken while a word is pending");

   a_run_id_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_run_valid |-> rsp_run_id == 8'd0)
      else $error("run id without a running job");

   a_wait_le_turn: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_done_valid |-> rsp_wait_len <= rsp_turnaround)
      else $error("wait exceeds turnaround");

   a_total_mono: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> rsp_wait_total >= $past(rsp_wait_total, 2))
      else $error("wait total decreased");
endmodule
